>>> sv/dtt_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer table package
// Shared constants, codes and types for the deadline timer table block.
// ----------------------------------------------------------------------------
package dtt_pkg;

    // Table geometry.
    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    // Field widths of one transaction.
    localparam int TIME_W     = 64;
    localparam int TID_W      = 4;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 72;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
    localparam logic [OP_W-1:0] OP_EXPIRE  = 3'd5;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_INACTIVE = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD,
        ST_CALC,
        ST_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_POST,
        ST_EXP_RD,
        ST_EXP_WR,
        ST_EMIT
    } t_state;

    // One result item.
    typedef struct packed {
        t_status            status;
        logic [TID_W-1:0]   timer_id;
        logic               fired;
        logic [TIME_W-1:0]  wait_ms;
        logic               at_front;
        logic               last;
    } t_result;

    // Running outcome of a scan over the deadline memory.
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [TIME_W-1:0]  dl;
        logic [CNT_W-1:0]   count;
    } t_scan_res;

endpackage

>>> sv/dtt_scan.sv
// ----------------------------------------------------------------------------
// Deadline scan unit
// Walks the deadline words streamed out of the memory, one per cycle, and
// keeps the earliest eligible entry (ties go to the lower slot) and a count
// of the eligible entries.
// ----------------------------------------------------------------------------
module dtt_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_valid,
    input  logic [dtt_pkg::IDX_W-1:0]    i_idx,
    input  logic [dtt_pkg::TIME_W-1:0]   i_dl,
    input  logic [dtt_pkg::TIME_W-1:0]   i_now,
    input  logic                         i_elig,
    input  logic                         i_due_mode,
    output dtt_pkg::t_scan_res           o_res
);
    import dtt_pkg::*;

    t_scan_res r_res;
    t_scan_res n_res;
    logic      hit;
    logic      take;

    // An entry counts when it is eligible and, in due mode, already due.
    // Entries arrive in slot order, so a strict compare keeps the lower slot.
    always_comb begin
        hit   = i_valid && i_elig && (!i_due_mode || (i_dl <= i_now));
        take  = hit && (!r_res.found || (i_dl < r_res.dl));
        n_res = r_res;
        if (i_start) begin
            n_res.found = 1'b0;
            n_res.count = '0;
        end else begin
            if (hit) begin
                n_res.count = r_res.count + CNT_W'(1);
            end
            if (take) begin
                n_res.found = 1'b1;
                n_res.idx   = i_idx;
                n_res.dl    = i_dl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> sv/deadline_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Deadline timer table
// Table of software timers with deadlines and periods held in memory.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Cancel, refresh and the unused opcodes
// make no pass over the deadline memory. A query, and a successful add or
// reset, each make one pass over the deadline memory, which has a single read
// port and delivers one entry a cycle. Expire makes one pass per fired timer,
// or a single pass with nothing due. Every result waits until the output
// register is free, so a stalled sink holds up each result. No clearing pass
// is needed after reset; the block is ready at once. A result waits in an
// output register, so the next transaction is taken while the last result of
// the previous one is still pending.
// ----------------------------------------------------------------------------
module deadline_timer_table_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: now_ms[63:0], slot[67:64], period_ms[131:68], repeat_req[132],
    //        now_based[133], zero fill[135:134]
    input  logic [dtt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: opcode[2:0]
    input  logic [dtt_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: timer_id[3:0], fired[4], wait_ms[68:5], at_front[69],
    //        zero fill[71:70]
    output logic [dtt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: status[1:0]
    output logic [dtt_pkg::STAT_W-1:0]       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import dtt_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);

    // Control state.
    t_state                 r_state;
    t_state                 n_state;
    logic [NUM_TIMERS-1:0]  r_active;
    logic [NUM_TIMERS-1:0]  n_active;
    logic                   r_front_pend;
    logic                   n_front_pend;
    logic                   r_out_vld;
    logic                   n_out_vld;
    logic                   r_pv;

    // Captured transaction and working registers.
    logic [OP_W-1:0]        r_op;
    logic [OP_W-1:0]        n_op;
    logic [TIME_W-1:0]      r_now;
    logic [TIME_W-1:0]      n_now;
    logic [TID_W-1:0]       r_slot;
    logic [TID_W-1:0]       n_slot;
    logic [TIME_W-1:0]      r_per;
    logic [TIME_W-1:0]      n_per;
    logic                   r_rep;
    logic                   n_rep;
    logic                   r_fnow;
    logic                   n_fnow;
    logic [TIME_W-1:0]      r_new_dl;
    logic [TIME_W-1:0]      n_new_dl;
    logic [NUM_TIMERS-1:0]  r_repeats;
    logic [NUM_TIMERS-1:0]  n_repeats;
    logic [NUM_TIMERS-1:0]  r_taken;
    logic [NUM_TIMERS-1:0]  n_taken;
    t_result                r_res;
    t_result                n_res;
    logic                   r_more;
    logic                   n_more;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic [IDX_W-1:0]       r_pidx;
    t_result                r_out;
    t_result                n_out;

    // Memory ports.
    logic [TIME_W-1:0]      mem_dl  [NUM_TIMERS];
    logic [TIME_W-1:0]      mem_per [NUM_TIMERS];
    logic [TIME_W-1:0]      rd_dl;
    logic [TIME_W-1:0]      rd_per;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       wr_addr;
    logic                   dl_we;
    logic                   per_we;
    logic [TIME_W-1:0]      dl_wd;

    // Miscellaneous decode.
    logic                   in_acc;
    logic                   out_free;
    logic                   all_active;
    logic [IDX_W-1:0]       free_idx;
    logic                   slot_ok;
    logic                   due_mode;
    logic                   scan_start;
    logic                   scan_elig;
    t_scan_res              scan_res;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign all_active    = &r_active;
    assign slot_ok       = r_active[r_slot[IDX_W-1:0]];
    assign due_mode      = (r_op == OP_EXPIRE);
    assign rd_addr       = (r_state == ST_SCAN) ? r_idx : r_slot[IDX_W-1:0];
    assign wr_addr       = r_slot[IDX_W-1:0];

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Deadline and period memories, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            mem_dl[wr_addr] <= dl_wd;
        end
        if (per_we) begin
            mem_per[wr_addr] <= r_per;
        end
        rd_dl  <= mem_dl[rd_addr];
        rd_per <= mem_per[rd_addr];
    end

    // Scan unit sees each memory word in the cycle after its read was issued.
    assign scan_start = (r_state != ST_SCAN) && (n_state == ST_SCAN);
    assign scan_elig  = r_active[r_pidx] && !(due_mode && r_taken[r_pidx]);

    dtt_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_valid    (r_pv),
        .i_idx      (r_pidx),
        .i_dl       (rd_dl),
        .i_now      (r_now),
        .i_elig     (scan_elig),
        .i_due_mode (due_mode),
        .o_res      (scan_res)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (r_op)
                    OP_ADD:     n_state = all_active ? ST_EMIT : ST_WR;
                    OP_REFRESH: n_state = slot_ok ? ST_RD : ST_EMIT;
                    OP_RESET:   n_state = slot_ok ? ST_RD : ST_EMIT;
                    OP_QUERY:   n_state = ST_SCAN;
                    OP_EXPIRE:  n_state = ST_SCAN;
                    default:    n_state = ST_EMIT;
                endcase
            end
            ST_RD: begin
                n_state = (r_op == OP_RESET && !r_fnow) ? ST_CALC : ST_WR;
            end
            ST_CALC: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                n_state = (r_op == OP_REFRESH) ? ST_EMIT : ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == IDX_LAST) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                if (due_mode && scan_res.count != '0) begin
                    n_state = ST_EXP_RD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EXP_RD: begin
                n_state = ST_EXP_WR;
            end
            ST_EXP_WR: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = r_more ? ST_SCAN : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and table updates for each sequencer state.
    always_comb begin
        n_op         = r_op;
        n_now        = r_now;
        n_slot       = r_slot;
        n_per        = r_per;
        n_rep        = r_rep;
        n_fnow       = r_fnow;
        n_new_dl     = r_new_dl;
        n_active     = r_active;
        n_repeats    = r_repeats;
        n_taken      = r_taken;
        n_front_pend = r_front_pend;
        n_res        = r_res;
        n_more       = r_more;
        n_idx        = (r_state == ST_SCAN) ? r_idx + IDX_W'(1) : '0;
        dl_we        = 1'b0;
        per_we       = 1'b0;
        dl_wd        = r_new_dl;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out        = r_out;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_op   = s_axis_tuser;
                    n_now  = s_axis_tdata[63:0];
                    n_slot = s_axis_tdata[67:64];
                    n_per  = s_axis_tdata[131:68];
                    n_rep  = s_axis_tdata[132];
                    n_fnow = s_axis_tdata[133];
                end
            end
            ST_DISPATCH: begin
                n_res          = '0;
                n_res.status   = STAT_OK;
                n_res.timer_id = r_slot;
                n_res.last     = 1'b1;
                n_more         = 1'b0;
                case (r_op)
                    OP_ADD: begin
                        if (all_active) begin
                            n_res.status   = STAT_FULL;
                            n_res.timer_id = '0;
                        end else begin
                            n_slot         = TID_W'(free_idx);
                            n_res.timer_id = TID_W'(free_idx);
                            n_new_dl       = r_now + r_per;
                        end
                    end
                    OP_CANCEL: begin
                        if (slot_ok) begin
                            n_active[r_slot[IDX_W-1:0]] = 1'b0;
                        end else begin
                            n_res.status = STAT_INACTIVE;
                        end
                    end
                    OP_REFRESH: begin
                        if (!slot_ok) begin
                            n_res.status = STAT_INACTIVE;
                        end
                    end
                    OP_RESET: begin
                        if (!slot_ok) begin
                            n_res.status = STAT_INACTIVE;
                        end
                    end
                    OP_QUERY: begin
                        n_front_pend   = 1'b0;
                        n_res.timer_id = '0;
                    end
                    OP_EXPIRE: begin
                        n_taken        = '0;
                        n_res.timer_id = '0;
                    end
                    default: begin
                        n_res.timer_id = '0;
                    end
                endcase
            end
            ST_RD: begin
                // The slot's old deadline and period are on the read port.
                if (r_op == OP_REFRESH) begin
                    n_new_dl = r_now + rd_per;
                end else if (r_fnow) begin
                    n_new_dl = r_now + r_per;
                end else begin
                    n_new_dl = rd_dl - rd_per;
                end
            end
            ST_CALC: begin
                // Second half of the rebase onto the old start.
                n_new_dl = r_new_dl + r_per;
            end
            ST_WR: begin
                dl_we  = 1'b1;
                per_we = (r_op == OP_ADD) || (r_op == OP_RESET);
                if (r_op == OP_ADD) begin
                    n_active[r_slot[IDX_W-1:0]]  = 1'b1;
                    n_repeats[r_slot[IDX_W-1:0]] = r_rep;
                end
            end
            ST_POST: begin
                case (r_op)
                    OP_QUERY: begin
                        if (!scan_res.found) begin
                            n_res.wait_ms = '1;
                        end else if (r_now >= scan_res.dl) begin
                            n_res.wait_ms = '0;
                        end else begin
                            n_res.wait_ms = scan_res.dl - r_now;
                        end
                    end
                    OP_EXPIRE: begin
                        n_res          = '0;
                        n_res.status   = STAT_OK;
                        n_res.last     = 1'b1;
                        n_more         = 1'b0;
                        if (scan_res.count != '0) begin
                            n_res.fired    = 1'b1;
                            n_res.timer_id = TID_W'(scan_res.idx);
                            n_res.last     = (scan_res.count == CNT_W'(1));
                            n_more         = (scan_res.count != CNT_W'(1));
                            n_slot         = TID_W'(scan_res.idx);
                            n_taken[scan_res.idx] = 1'b1;
                        end
                    end
                    default: begin
                        // Add and reset: report a new earliest timer once.
                        if (scan_res.found && scan_res.idx == r_slot[IDX_W-1:0] &&
                            !r_front_pend) begin
                            n_res.at_front = 1'b1;
                            n_front_pend   = 1'b1;
                        end
                    end
                endcase
            end
            ST_EXP_WR: begin
                // Fired timer: re-arm from now or free the slot.
                if (r_repeats[r_slot[IDX_W-1:0]]) begin
                    dl_we = 1'b1;
                    dl_wd = r_now + rd_per;
                end else begin
                    n_active[r_slot[IDX_W-1:0]] = 1'b0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= '0;
            r_front_pend <= 1'b0;
            r_out_vld    <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_front_pend <= n_front_pend;
            r_out_vld    <= n_out_vld;
            r_pv         <= (r_state == ST_SCAN);
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_now     <= n_now;
        r_slot    <= n_slot;
        r_per     <= n_per;
        r_rep     <= n_rep;
        r_fnow    <= n_fnow;
        r_new_dl  <= n_new_dl;
        r_repeats <= n_repeats;
        r_taken   <= n_taken;
        r_res     <= n_res;
        r_more    <= n_more;
        r_idx     <= n_idx;
        r_pidx    <= r_idx;
        r_out     <= n_out;
    end

    // Output transaction.
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {2'b00, r_out.at_front, r_out.wait_ms, r_out.fired,
                            r_out.timer_id};

    // A fired timer has been marked so the next pass skips it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_res.fired) |-> r_taken[r_res.timer_id[IDX_W-1:0]])
        else $error("fired timer not marked as taken");

    // A full report only when every slot is in use.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_res.status == STAT_FULL) |-> all_active)
        else $error("table full reported with a free slot");

    // A front report always leaves the pending flag set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_res.at_front) |-> r_front_pend)
        else $error("front reported without pending flag");

    // The scan never counts more entries than the table holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.count <= CNT_W'(NUM_TIMERS))
        else $error("scan count exceeds table size");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Deadline timer table testbench
// Drives timer operations into the stream input of the timer table and checks
// every result against a cycle-free model of the table kept in this module.
// A directed part exercises the empty and the full table, wrapping deadlines,
// ties and the spare opcodes. Random traffic follows, with time that mostly
// moves forward and a little noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import dtt_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 60;

    // Opcodes that the block does not use.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: now_ms, slot, period_ms, repeat_req, now_based, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // tuser: opcode
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // tdata: timer_id, fired, wait_ms, at_front, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: status
    logic [STAT_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    // Model of the timer table.
    logic [TIME_W-1:0] tt_deadline [NUM_TIMERS];
    logic [TIME_W-1:0] tt_period   [NUM_TIMERS];
    bit                tt_active   [NUM_TIMERS];
    bit                tt_repeat   [NUM_TIMERS];
    bit                tt_front_flag;

    // Results the table owes, oldest first.
    t_result timer_results_q [$];

    int errors      = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_fired     = 0;
    int n_full_adds = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit steady_flow = 1'b0;
    logic [TIME_W-1:0] wall_ms;

    deadline_timer_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Earliest armed timer by deadline, lower slot first on a tie.
    function automatic int earliest_slot();
        int best;
        best = NUM_TIMERS;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tt_active[i] && (best == NUM_TIMERS || tt_deadline[i] < tt_deadline[best])) begin
                best = i;
            end
        end
        return best;
    endfunction

    // A timer just placed reports the front once until the next query.
    function automatic logic claim_front(input int s);
        if (earliest_slot() == s && !tt_front_flag) begin
            tt_front_flag = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one operation to the model and queues the results it owes.
    function automatic void timer_table_apply(input logic [OP_W-1:0] op,
                                              input logic [TIME_W-1:0] now,
                                              input logic [TID_W-1:0] slot,
                                              input logic [TIME_W-1:0] per,
                                              input logic rep,
                                              input logic fnow);
        t_result r;
        int      pick;
        int      fire_order [$];
        bit      taken [NUM_TIMERS];
        r = '0;
        r.status = STAT_OK;
        r.last = 1'b1;
        case (op)
            OP_ADD: begin
                pick = NUM_TIMERS;
                for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
                    if (!tt_active[i]) begin
                        pick = i;
                    end
                end
                if (pick == NUM_TIMERS) begin
                    r.status = STAT_FULL;
                    n_full_adds++;
                end else begin
                    tt_active[pick] = 1'b1;
                    tt_period[pick] = per;
                    tt_repeat[pick] = rep;
                    tt_deadline[pick] = now + per;
                    r.timer_id = pick[TID_W-1:0];
                    r.at_front = claim_front(pick);
                end
            end
            OP_CANCEL, OP_REFRESH, OP_RESET: begin
                r.timer_id = slot;
                if (!tt_active[slot]) begin
                    r.status = STAT_INACTIVE;
                end else if (op == OP_CANCEL) begin
                    tt_active[slot] = 1'b0;
                end else if (op == OP_REFRESH) begin
                    tt_deadline[slot] = now + tt_period[slot];
                end else begin
                    tt_deadline[slot] = fnow ? now + per
                                             : tt_deadline[slot] - tt_period[slot] + per;
                    tt_period[slot] = per;
                    r.at_front = claim_front(slot);
                end
            end
            OP_QUERY: begin
                pick = earliest_slot();
                tt_front_flag = 1'b0;
                if (pick == NUM_TIMERS) begin
                    r.wait_ms = TIME_MAX;
                end else if (now >= tt_deadline[pick]) begin
                    r.wait_ms = '0;
                end else begin
                    r.wait_ms = tt_deadline[pick] - now;
                end
            end
            OP_EXPIRE: begin
                // Collect due timers in firing order before any of them re-arms.
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    taken[i] = 1'b0;
                end
                forever begin
                    pick = NUM_TIMERS;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (tt_active[i] && !taken[i] && tt_deadline[i] <= now &&
                            (pick == NUM_TIMERS || tt_deadline[i] < tt_deadline[pick])) begin
                            pick = i;
                        end
                    end
                    if (pick == NUM_TIMERS) begin
                        break;
                    end
                    taken[pick] = 1'b1;
                    fire_order.insert(fire_order.size(), pick);
                end
                foreach (fire_order[k]) begin
                    r.timer_id = fire_order[k][TID_W-1:0];
                    r.fired = 1'b1;
                    r.last = (k == fire_order.size() - 1);
                    timer_results_q.insert(timer_results_q.size(), r);
                    if (tt_repeat[fire_order[k]]) begin
                        tt_deadline[fire_order[k]] = now + tt_period[fire_order[k]];
                    end else begin
                        tt_active[fire_order[k]] = 1'b0;
                    end
                end
                if (fire_order.size() > 0) begin
                    return;
                end
            end
            default: begin
            end
        endcase
        timer_results_q.insert(timer_results_q.size(), r);
    endfunction

    // Sends one operation after a random gap; valid stays up afterwards.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                             input logic [TID_W-1:0] slot, input logic [TIME_W-1:0] per,
                             input logic rep, input logic fnow);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, fnow, rep, per, slot, now};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        timer_table_apply(op, now, slot, per, rep, fnow);
        n_items++;
    endtask

    // Drops valid and waits until every owed result has come back.
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (timer_results_q.size() != 0) @(posedge i_clk);
    endtask

    // Empty table: query, expire, operations on dead slots, spare opcodes.
    task automatic test_empty_table();
        send_item(OP_QUERY,   64'd123,  4'd0,  64'd0,    1'b0, 1'b0);
        send_item(OP_EXPIRE,  TIME_MAX, 4'd0,  64'd0,    1'b0, 1'b0);
        send_item(OP_CANCEL,  64'd0,    4'd15, 64'd0,    1'b0, 1'b0);
        send_item(OP_REFRESH, 64'd5,    4'd0,  64'd9,    1'b0, 1'b0);
        send_item(OP_RESET,   64'd5,    4'd7,  TIME_MAX, 1'b1, 1'b1);
        send_item(OP_SPARE_6, TIME_MAX, 4'd15, TIME_MAX, 1'b1, 1'b1);
        send_item(OP_SPARE_7, {$urandom, $urandom}, 4'd3, {$urandom, $urandom}, 1'b1, 1'b0);
    endtask

    // Fill every slot, overflow, re-arm, reset both ways, then fire them all.
    task automatic test_fill_and_fire();
        logic [TIME_W-1:0] per;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            case (i)
                0:       per = '0;
                1:       per = TIME_MAX;
                2, 3:    per = 64'd50;
                15:      per = 64'h8000_0000_0000_0000;
                default: per = 64'(i * 10);
            endcase
            send_item(OP_ADD, 64'd1000, 4'(i), per, i[0], 1'b0);
        end
        send_item(OP_ADD,     64'd1000, 4'd0, 64'd1,  1'b1, 1'b0);
        send_item(OP_QUERY,   64'd1000, 4'd0, 64'd0,  1'b0, 1'b0);
        send_item(OP_REFRESH, 64'd2000, 4'd1, 64'd0,  1'b0, 1'b0);
        send_item(OP_RESET,   64'd0,    4'd3, 64'd0,  1'b0, 1'b1);
        send_item(OP_RESET,   64'd0,    4'd2, 64'd7,  1'b0, 1'b0);
        send_item(OP_EXPIRE,  TIME_MAX, 4'd0, 64'd0,  1'b0, 1'b0);
        send_item(OP_QUERY,   64'd0,    4'd0, 64'd0,  1'b0, 1'b0);
    endtask

    // Random traffic around a clock that mostly moves forward.
    task automatic test_random_traffic(input int count);
        int                live [$];
        int                r;
        logic [OP_W-1:0]   op;
        logic [TID_W-1:0]  slot;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] per;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25)      op = OP_ADD;
            else if (r < 35) op = OP_CANCEL;
            else if (r < 45) op = OP_REFRESH;
            else if (r < 60) op = OP_RESET;
            else if (r < 75) op = OP_QUERY;
            else if (r < 95) op = OP_EXPIRE;
            else             op = r[0] ? OP_SPARE_6 : OP_SPARE_7;
            // Aim most slot operations at live timers.
            live.delete();
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (tt_active[i]) begin
                    live.insert(live.size(), i);
                end
            end
            if (live.size() > 0 && $urandom_range(0, 4) != 0) begin
                slot = 4'(live[$urandom_range(0, live.size() - 1)]);
            end else begin
                slot = 4'($urandom_range(0, NUM_TIMERS - 1));
            end
            wall_ms = wall_ms + 64'($urandom_range(0, 60));
            now = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : wall_ms;
            per = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 150));
            send_item(op, now, slot, per, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Sink side: random stalls unless a steady stretch is running.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    task automatic field_check(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare each result transaction with the oldest one owed.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (timer_results_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = timer_results_q.pop_front();
                if (want.fired) begin
                    n_fired++;
                end
                field_check("status",   64'(want.status),   64'(m_axis_tuser));
                field_check("timer_id", 64'(want.timer_id), 64'(m_axis_tdata[3:0]));
                field_check("fired",    64'(want.fired),    64'(m_axis_tdata[4]));
                field_check("wait_ms",  want.wait_ms,       m_axis_tdata[68:5]);
                field_check("at_front", 64'(want.at_front), 64'(m_axis_tdata[69]));
                field_check("last",     64'(want.last),     64'(m_axis_tlast));
            end
        end
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        wall_ms = {24'h0, $urandom, 8'h0};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_and_fire();
        wait_drain();
        test_random_traffic(40);
        wait_drain();
        steady_flow = 1'b1;
        test_random_traffic(15);
        steady_flow = 1'b0;
        test_random_traffic(15);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d operations and checked %0d results.", n_items, n_results);
        $display("%0d timers fired and %0d adds hit a full table.", n_fired, n_full_adds);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/dtt_pkg.sv
sv/dtt_scan.sv
sv/deadline_timer_table_unit.sv
tb/tb.sv
